/* design/linear_chirp_generator_assert.svh */
// Assertion macros for the chirp generator.
// Needs no package; expands to concurrent assertions unless SYNTH is defined.
`ifndef LINEAR_CHIRP_GENERATOR_ASSERT_SVH
`define LINEAR_CHIRP_GENERATOR_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LCG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcg assertion failed");
// next-cycle implication
`define LCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcg assertion failed");
`else
`define LCG_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LCG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/lcg_pkg.sv */
// Shared widths, constants and register map of the chirp generator.
// No dependencies.
package lcg_pkg;

    localparam int PHASE_WIDTH = 32;
    localparam int INDEX_WIDTH = 24;
    localparam int AMP_WIDTH   = 16;
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 4;

    // pi/2 (2*atan(1)) in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        REG_START_STEP   = 2'd0,
        REG_STEP_DELTA   = 2'd1,
        REG_AMPLITUDE    = 2'd2,
        REG_SAMPLE_COUNT = 2'd3
    } reg_idx_t;

    localparam logic [INDEX_WIDTH-1:0] SAMPLE_COUNT_RESET = 24'd1000;

endpackage

/* design/lcg_tick_if.sv */
// Input channel of the chirp generator: one beat per sample tick.
// Depends on nothing.
interface lcg_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

/* design/lcg_sample_if.sv */
// Output channel of the chirp generator: one beat per chirp sample.
// Depends on lcg_pkg for the index width.
interface lcg_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_WIDTH-1:0]      sample;
    logic [lcg_pkg::INDEX_WIDTH-1:0]     sample_index;
    logic                                last;

    modport source (output valid, output sample, output sample_index, output last,
                    input ready);
    modport sink (input valid, input sample, input sample_index, input last,
                  output ready);
endinterface

/* design/linear_chirp_generator.sv */
// Linear chirp generator: each accepted tick beat advances a phase accumulator whose step
// grows linearly, and yields one sample of A*sin(2*pi*phase) until sample_count samples of
// the sweep are out; a restart beat starts the sweep over with a zero sample at index 0.
// Ticks after the sweep has ended give no sample. One tick is taken per clock cycle while
// tick.ready is high (it falls when the pipeline is full and smp.ready is low); each sample
// passes through the phase stage, sine ROM read, amplitude multiply and sign/output
// register in that order. The phase/step accumulator update is done in the input stage.
// The quarter-wave sine ROM holds 2^TABLE_ADDR_BITS entries computed at elaboration.
// start_step takes effect at the next restart.
`include "linear_chirp_generator_assert.svh"

module linear_chirp_generator #(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcg_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [lcg_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [lcg_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    lcg_tick_if.sink                            tick,
    lcg_sample_if.source                        smp
);
    import lcg_pkg::*;

    localparam int TBL_N = 1 << TABLE_ADDR_BITS;
    localparam int MAG_W = SAMPLE_WIDTH - 1;

    typedef logic [MAG_W-1:0] rom_t [TBL_N];

    // shift-subtract quotient, used at elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // integer Taylor series in Q2.30, evaluated at elaboration only
    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] sin_max;
        logic [63:0] div;
        logic [63:0] scaled;
        for (int k = 0; k < TBL_N; k++) begin
            x    = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (TABLE_ADDR_BITS + 1);
            term = x;
            sum  = x;
            for (int n = 1; n <= 8; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                div  = 64'((2 * n) * (2 * n + 1));
                term = div_u64(term, div);
                if (n[0]) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end
                else begin
                    sum = sum + term;
                end
            end
            if (sum > (64'd1 << 30)) begin
                sum = 64'd1 << 30;
            end
            sin_max = (64'd1 << MAG_W) - 64'd1;
            scaled  = (sum * sin_max + (64'd1 << 29)) >> 30;
            rom[k]  = scaled[MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // ---------------- configuration registers ----------------
    logic [PHASE_WIDTH-1:0] start_step_reg;
    logic [PHASE_WIDTH-1:0] step_delta_reg;
    logic [AMP_WIDTH-1:0]   amplitude_reg;
    logic [INDEX_WIDTH-1:0] sample_count_reg;
    logic                   cfg_wr;
    reg_idx_t               cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_step_reg   <= '0;
            step_delta_reg   <= '0;
            amplitude_reg    <= '0;
            sample_count_reg <= SAMPLE_COUNT_RESET;
        end
        else if (cfg_wr) begin
            case (cfg_idx)
                REG_START_STEP:   start_step_reg   <= pwdata;
                REG_STEP_DELTA:   step_delta_reg   <= pwdata;
                REG_AMPLITUDE:    amplitude_reg    <= pwdata[AMP_WIDTH-1:0];
                REG_SAMPLE_COUNT: sample_count_reg <= pwdata[INDEX_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_START_STEP:   prdata = start_step_reg;
            REG_STEP_DELTA:   prdata = step_delta_reg;
            REG_AMPLITUDE:    prdata = {{(APB_DATA_WIDTH-AMP_WIDTH){1'b0}}, amplitude_reg};
            REG_SAMPLE_COUNT: prdata = {{(APB_DATA_WIDTH-INDEX_WIDTH){1'b0}}, sample_count_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic free1, free2, free3, free4;
    logic in_acc;

    assign free4  = !out_valid_reg || smp.ready;
    assign free3  = !s3_valid_reg || free4;
    assign free2  = !s2_valid_reg || free3;
    assign free1  = !s1_valid_reg || free2;
    assign tick.ready = free1;
    assign in_acc = tick.valid && tick.ready;

    // ---------------- sweep state ----------------
    logic [PHASE_WIDTH-1:0] phase_acc_reg, phase_acc_next;
    logic [PHASE_WIDTH-1:0] phase_step_reg, phase_step_next;
    logic [INDEX_WIDTH-1:0] next_index_reg, next_index_next;
    logic                   sweep_done_reg, sweep_done_next;
    logic [INDEX_WIDTH-1:0] final_idx;
    logic [PHASE_WIDTH-1:0] phase_sum;
    logic                   emit;
    logic                   emit_last;
    logic [INDEX_WIDTH-1:0] emit_index;

    assign final_idx = (sample_count_reg == '0) ? '0 : sample_count_reg - 1'b1;
    assign phase_sum = phase_acc_reg + phase_step_reg;

    always_comb begin
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        next_index_next = next_index_reg;
        sweep_done_next = sweep_done_reg;
        emit            = 1'b0;
        emit_last       = 1'b0;
        emit_index      = next_index_reg;
        if (in_acc) begin
            if (tick.restart) begin
                emit            = 1'b1;
                emit_last       = (final_idx == '0);
                emit_index      = '0;
                phase_acc_next  = '0;
                phase_step_next = start_step_reg;
                next_index_next = INDEX_WIDTH'(1);
                sweep_done_next = emit_last;
            end
            else if (!sweep_done_reg) begin
                emit            = 1'b1;
                emit_last       = (next_index_reg >= final_idx);
                phase_acc_next  = phase_sum;
                phase_step_next = phase_step_reg + step_delta_reg;
                next_index_next = next_index_reg + 1'b1;
                sweep_done_next = emit_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            next_index_reg <= '0;
            sweep_done_reg <= 1'b1;
        end
        else begin
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            next_index_reg <= next_index_next;
            sweep_done_reg <= sweep_done_next;
        end
    end

    // ---------------- stage 1: phase of the sample ----------------
    logic                   s1_zero_reg;
    logic [PHASE_WIDTH-1:0] s1_phase_reg;
    logic [INDEX_WIDTH-1:0] s1_index_reg;
    logic                   s1_last_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (free1) begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk) begin
        if (free1) begin
            s1_zero_reg  <= tick.restart;
            s1_phase_reg <= phase_acc_next;
            s1_index_reg <= emit_index;
            s1_last_reg  <= emit_last;
        end
    end

    // ---------------- stage 2: quarter-wave ROM read ----------------
    logic [TABLE_ADDR_BITS-1:0] rom_addr;
    logic [MAG_W-1:0]           s2_mag_reg;
    logic                       s2_neg_reg;
    logic                       s2_zero_reg;
    logic [INDEX_WIDTH-1:0]     s2_index_reg;
    logic                       s2_last_reg;

    // odd quadrants read the table mirrored
    assign rom_addr = s1_phase_reg[PHASE_WIDTH-3 -: TABLE_ADDR_BITS]
                      ^ {TABLE_ADDR_BITS{s1_phase_reg[PHASE_WIDTH-2]}};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end
        else if (free2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (free2) begin
            s2_mag_reg   <= SINE_ROM[rom_addr];
            s2_neg_reg   <= s1_phase_reg[PHASE_WIDTH-1];
            s2_zero_reg  <= s1_zero_reg;
            s2_index_reg <= s1_index_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // ---------------- stage 3: amplitude scaling ----------------
    logic [MAG_W+AMP_WIDTH-1:0] product;
    logic [MAG_W-1:0]           s3_mag_reg;
    logic                       s3_neg_reg;
    logic [INDEX_WIDTH-1:0]     s3_index_reg;
    logic                       s3_last_reg;

    assign product = (MAG_W+AMP_WIDTH)'(s2_mag_reg) * (MAG_W+AMP_WIDTH)'(amplitude_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s3_valid_reg <= 1'b0;
        end
        else if (free3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (free3) begin
            s3_mag_reg   <= s2_zero_reg ? '0 : product[MAG_W+AMP_WIDTH-1:AMP_WIDTH];
            s3_neg_reg   <= s2_neg_reg;
            s3_index_reg <= s2_index_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    // ---------------- stage 4: sign and output register ----------------
    logic [SAMPLE_WIDTH-1:0] mag_ext;
    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic [INDEX_WIDTH-1:0]  index_reg;
    logic                    last_reg;

    assign mag_ext = {1'b0, s3_mag_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (free4) begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (free4) begin
            sample_reg <= s3_neg_reg ? (~mag_ext + 1'b1) : mag_ext;
            index_reg  <= s3_index_reg;
            last_reg   <= s3_last_reg;
        end
    end

    assign smp.valid        = out_valid_reg;
    assign smp.sample       = sample_reg;
    assign smp.sample_index = index_reg;
    assign smp.last         = last_reg;

    // ---------------- checks ----------------
    `LCG_ASSERT_NEXT(a_restart_zero_sample, clk, rst_n, in_acc && tick.restart,
        s1_valid_reg && s1_zero_reg && (s1_index_reg == '0) && (next_index_reg == INDEX_WIDTH'(1)))
    `LCG_ASSERT_NEXT(a_idle_no_beat, clk, rst_n, in_acc && !tick.restart && sweep_done_reg,
        !s1_valid_reg)
    `LCG_ASSERT_NEXT(a_idle_holds_phase, clk, rst_n, sweep_done_reg && !(in_acc && tick.restart),
        $stable(phase_acc_reg) && $stable(phase_step_reg) && sweep_done_reg)

endmodule
